[rtl/core/lvl_pkg.sv]
`default_nettype none
package lvl_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int LEN_W      = AW + 1;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int AMP_W      = 32;
  localparam int MAG_W      = SMP_W + 1;
  localparam int DIFF_W     = AMP_W + 2;
  localparam int XPROD_W    = DIFF_W + LEN_W;
  localparam int DVD_W      = 39;
  localparam int DVS_W      = AMP_W;
  localparam int CFG_W      = 16;

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(RING_DEPTH);

  localparam logic [7:0]        STRENGTH_RST = 8'd204;
  localparam logic [GAIN_W-1:0] MAX_GAIN_RST = 16'd5120;
  localparam logic [LEN_W-1:0]  LENGTH_RST   = LEN_W'(RING_DEPTH);
  localparam logic [1:0]        CHANNELS_RST = 2'd2;

  // 2^(2^-k) in Q1.30, k = 8 - bit position of the fraction
  localparam logic [30:0] EXP_TAB [8] = '{
    31'd1076653033, 31'd1079572136, 31'd1085434106, 31'd1097253708,
    31'd1121280435, 31'd1170923762, 31'd1276901417, 31'd1518500250
  };

  typedef enum logic [1:0] {
    CFG_STRENGTH = 2'd0,
    CFG_MAX_GAIN = 2'd1,
    CFG_LENGTH   = 2'd2,
    CFG_CHANNELS = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLR_INIT, ST_CLEAR, ST_IDLE,
    ST_G_START, ST_G_DIV, ST_G_NORM, ST_G_SQ_MUL, ST_G_SQ_UPD, ST_G_LOG,
    ST_G_EXP_CHK, ST_G_EXP_MUL, ST_G_EXP_UPD, ST_G_EXP_FIN, ST_G_CAP,
    ST_RING, ST_SCALE, ST_OUT, ST_TRK, ST_INC_MUL, ST_INC_SEL,
    ST_SC_RD, ST_SC_MAG, ST_SC_MUL, ST_SC_CMP, ST_SC_FIN, ST_SLOPE_DIV
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR_INIT, OP_CLEAR, OP_LATCH,
    OP_G_START, OP_G_DIV, OP_G_NORM, OP_G_SQ_MUL, OP_G_SQ_UPD, OP_G_LOG,
    OP_G_EXP_CHK, OP_G_EXP_MUL, OP_G_EXP_UPD, OP_G_EXP_FIN, OP_G_CAP,
    OP_RING, OP_SCALE, OP_OUT, OP_TRK, OP_INC_MUL, OP_INC_SEL,
    OP_SC_RD, OP_SC_MAG, OP_SC_MUL, OP_SC_CMP, OP_SC_FIN, OP_SLOPE_DIV
  } dp_op_t;

  typedef struct packed {
    logic clr_done;
    logic amp_zero;
    logic amp_big;
    logic norm_done;
    logic k_last;
    logic exp_sat;
    logic div_done;
    logic out_busy;
    logic rescan;
    logic scan_last;
    logic cfg_flush;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/lvl_ring.sv]
`default_nettype none
module lvl_ring import lvl_pkg::*; (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we0,
  input  logic             we1,
  input  logic [SMP_W-1:0] wdata0,
  input  logic [SMP_W-1:0] wdata1,
  output logic [SMP_W-1:0] rdata0,
  output logic [SMP_W-1:0] rdata1
);

  logic [SMP_W-1:0] mem0 [RING_DEPTH];
  logic [SMP_W-1:0] mem1 [RING_DEPTH];

  // read-first: a write returns the old entry
  always_ff @(posedge clk) begin
    rdata0 <= mem0[addr];
    if (we0) begin
      mem0[addr] <= wdata0;
    end
  end

  always_ff @(posedge clk) begin
    rdata1 <= mem1[addr];
    if (we1) begin
      mem1[addr] <= wdata1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/lvl_div.sv]
`default_nettype none
module lvl_div import lvl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   part;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign part     = {rem, dvd[DVD_W-1]};
  assign diff     = part - {1'b0, dvs};
  assign fits     = part >= {1'b0, dvs};
  assign quotient = dvd;

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[DVS_W-1:0] : part[DVS_W-1:0];
        dvd <= {dvd[DVD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/lvl_datapath.sv]
`default_nettype none
module lvl_datapath import lvl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [SMP_W-1:0]  in_left,
  input  logic [SMP_W-1:0]  in_right,
  input  dp_op_t            op,
  output dp_status_t        st,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SMP_W-1:0]  out_left,
  output logic [SMP_W-1:0]  out_right,
  output logic              out_prefill,
  output logic [GAIN_W-1:0] out_gain
);

  function automatic logic [MAG_W-1:0] mag16(logic [SMP_W-1:0] v);
    logic [MAG_W-1:0] x;
    x = {v[SMP_W-1], v};
    return v[SMP_W-1] ? MAG_W'(~x + 1'b1) : x;
  endfunction

  // product / 256 toward zero, saturated to 16 bits
  function automatic logic [SMP_W-1:0] scale_sat(logic signed [32:0] p);
    logic signed [24:0] q;
    q = p[32:8];
    if (p[32] && (p[7:0] != 8'd0)) begin
      q = q + 25'sd1;
    end
    if (q > 25'sd32767) begin
      return 16'h7FFF;
    end else if (q < -25'sd32768) begin
      return 16'h8000;
    end
    return q[15:0];
  endfunction

  // configuration
  logic [7:0]        strength;
  logic [GAIN_W-1:0] max_gain;
  logic [LEN_W-1:0]  length_in_use;
  logic [1:0]        channels_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength        <= STRENGTH_RST;
      max_gain        <= MAX_GAIN_RST;
      length_in_use   <= LENGTH_RST;
      channels_in_use <= CHANNELS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STRENGTH: strength        <= cfg_data[7:0];
        CFG_MAX_GAIN: max_gain        <= cfg_data[GAIN_W-1:0];
        CFG_LENGTH:   length_in_use   <= cfg_data[LEN_W-1:0];
        CFG_CHANNELS: channels_in_use <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] len;
  logic [AW-1:0]    len_m1;
  logic             two_ch;

  always_comb begin
    if (length_in_use < LEN_MIN) begin
      len = LEN_MIN;
    end else if (length_in_use > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = length_in_use;
    end
  end
  assign len_m1 = AW'(len - 1'b1);
  assign two_ch = channels_in_use[1];

  // tracker and work registers
  logic [AW-1:0]            wp, pp, clr_addr, peak_gap, i_cnt, idx, best_i;
  logic signed [AMP_W-1:0]  slope;
  logic [MAG_W-1:0]         pm, new_mag, best_mag, cand_m;
  logic [AMP_W-1:0]         avg;
  logic [LEN_W-1:0]         prefill;
  logic [SMP_W-1:0]         smp_l, smp_r;
  logic [GAIN_W-1:0]        g;
  logic [30:0]              m, r;
  logic [4:0]               s;
  logic [7:0]               frac;
  logic [2:0]               k;
  logic [12:0]              e;
  logic [61:0]              prod;
  logic signed [32:0]       prod_l, prod_r;
  logic signed [DIFF_W-1:0] pd, nd, best_diff, cand_d;
  logic signed [XPROD_W-1:0] prod_a, prod_b;
  logic                     div_neg;

  // ring
  logic [AW-1:0]    ring_addr;
  logic             ring_we0, ring_we1;
  logic [SMP_W-1:0] ring_wd0, ring_wd1, ring_rd0, ring_rd1;

  always_comb begin
    ring_addr = wp;
    ring_we0  = 1'b0;
    ring_we1  = 1'b0;
    ring_wd0  = smp_l;
    ring_wd1  = smp_r;
    case (op)
      OP_CLEAR: begin
        ring_addr = clr_addr;
        ring_we0  = 1'b1;
        ring_we1  = 1'b1;
        ring_wd0  = '0;
        ring_wd1  = '0;
      end
      OP_RING: begin
        ring_we0 = 1'b1;
        ring_we1 = two_ch;
      end
      OP_SC_RD: ring_addr = idx;
      default: ;
    endcase
  end

  lvl_ring u_ring (
    .clk    (clk),
    .addr   (ring_addr),
    .we0    (ring_we0),
    .we1    (ring_we1),
    .wdata0 (ring_wd0),
    .wdata1 (ring_wd1),
    .rdata0 (ring_rd0),
    .rdata1 (ring_rd1)
  );

  // combinational helpers
  logic [LEN_W-1:0]         wp_inc, idx_inc, pp_sum, dist_raw;
  logic [AW-1:0]            wp_wrap, idx_wrap, dist_c;
  logic signed [DIFF_W-1:0] avg_sum, pd_c, nd_c;
  logic [AMP_W-1:0]         avg_new;
  logic [MAG_W-1:0]         in_mag, rd_mag0, rd_mag1, rd_mag;
  logic [31:0]              sq;
  logic [12:0]              neg_log;
  logic [20:0]              e_full;
  logic [37:0]              exp_shift;
  logic                     take;

  assign wp_inc   = {1'b0, wp} + 1'b1;
  assign wp_wrap  = (wp_inc == len) ? '0 : wp_inc[AW-1:0];
  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign idx_wrap = (idx_inc == len) ? '0 : idx_inc[AW-1:0];

  assign avg_sum = $signed({2'b00, avg}) + $signed({{2{slope[AMP_W-1]}}, slope});
  assign avg_new = avg_sum[DIFF_W-1] ? '0 :
                   avg_sum[AMP_W]    ? {AMP_W{1'b1}} : avg_sum[AMP_W-1:0];

  assign in_mag  = (two_ch && (mag16(smp_r) > mag16(smp_l))) ? mag16(smp_r) : mag16(smp_l);
  assign rd_mag0 = mag16(ring_rd0);
  assign rd_mag1 = two_ch ? mag16(ring_rd1) : '0;
  assign rd_mag  = (rd_mag1 > rd_mag0) ? rd_mag1 : rd_mag0;

  assign pd_c = $signed({2'b00, pm, 15'b0}) - $signed({2'b00, avg});
  assign nd_c = $signed({2'b00, new_mag, 15'b0}) - $signed({2'b00, avg});

  assign dist_raw = (pp >= wp) ? {1'b0, pp} - {1'b0, wp} : {1'b0, pp} + len - {1'b0, wp};
  assign dist_c   = (dist_raw[AW-1:0] == '0) ? AW'(1) : dist_raw[AW-1:0];

  assign pp_sum = {1'b0, wp} + {1'b0, best_i};

  assign sq        = prod[61:30];
  assign neg_log   = {s, 8'b0} - {5'b0, frac};
  assign e_full    = strength * neg_log;
  assign exp_shift = {7'b0, r} << e[10:8];
  assign take      = prod_a >= prod_b;

  // divider, shared by the gain for amplitude above unity and the slopes
  logic                     div_start, div_done;
  logic signed [DIFF_W-1:0] num;
  logic [DIFF_W-1:0]        num_abs;
  logic [DVD_W-1:0]         dvd, quo;
  logic [DVS_W-1:0]         dvs;

  always_comb begin
    num = best_diff;
    dvs = DVS_W'(best_i);
    case (op)
      OP_INC_SEL: begin
        num = take ? nd : pd;
        dvs = take ? DVS_W'(len_m1) : DVS_W'(peak_gap);
      end
      OP_G_START: dvs = avg;
      default: ;
    endcase
    num_abs = num[DIFF_W-1] ? DIFF_W'(-num) : num;
    dvd = (op == OP_G_START) ? DVD_W'(1) << (DVD_W - 1) : DVD_W'(num_abs);
  end

  assign div_start = ((op == OP_G_START) && st.amp_big) || (op == OP_INC_SEL) ||
                     (op == OP_SC_FIN);

  lvl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // status
  assign st.clr_done  = clr_addr == {AW{1'b1}};
  assign st.amp_zero  = avg == '0;
  assign st.amp_big   = avg > (AMP_W'(1) << 30);
  assign st.norm_done = m[30];
  assign st.k_last    = k == 3'd7;
  assign st.exp_sat   = e[12:8] >= 5'd8;
  assign st.div_done  = div_done;
  assign st.out_busy  = out_valid && !out_ready;
  assign st.rescan    = wp == pp;
  assign st.scan_last = i_cnt == len_m1;
  assign st.cfg_flush = cfg_we && ((cfg_idx_t'(cfg_index) == CFG_LENGTH) ||
                                   (cfg_idx_t'(cfg_index) == CFG_CHANNELS));

  always_ff @(posedge clk) begin
    case (op)
      OP_CLR_INIT: begin
        wp       <= '0;
        pp       <= '0;
        slope    <= '0;
        pm       <= '0;
        avg      <= '0;
        prefill  <= len;
        clr_addr <= '0;
      end
      OP_CLEAR: clr_addr <= clr_addr + 1'b1;
      OP_LATCH: begin
        smp_l <= in_left;
        smp_r <= in_right;
      end
      OP_G_START: begin
        g    <= '0;
        m    <= avg[30:0];
        s    <= '0;
        frac <= '0;
        k    <= '0;
      end
      OP_G_DIV: if (div_done) g <= quo[GAIN_W-1:0];
      OP_G_NORM: begin
        if (!m[30]) begin
          m <= {m[29:0], 1'b0};
          s <= s + 1'b1;
        end
      end
      OP_G_SQ_MUL: prod <= m * m;
      OP_G_SQ_UPD: begin
        frac <= {frac[6:0], sq[31]};
        m    <= sq[31] ? sq[31:1] : sq[30:0];
        k    <= k + 1'b1;
      end
      OP_G_LOG: begin
        e <= e_full[20:8];
        k <= '0;
        r <= 31'd1 << 30;
      end
      OP_G_EXP_CHK: if (st.exp_sat) g <= {GAIN_W{1'b1}};
      OP_G_EXP_MUL: prod <= r * EXP_TAB[k];
      OP_G_EXP_UPD: begin
        if (e[k]) r <= prod[60:30];
        k <= k + 1'b1;
      end
      OP_G_EXP_FIN: g <= exp_shift[37:22];
      OP_G_CAP: if ((max_gain != '0) && (g > max_gain)) g <= max_gain;
      OP_SCALE: begin
        prod_l <= $signed(ring_rd0) * $signed({1'b0, g});
        prod_r <= $signed(ring_rd1) * $signed({1'b0, g});
      end
      OP_OUT: begin
        new_mag <= in_mag;
        wp      <= wp_wrap;
        avg     <= avg_new;
        if (prefill != '0) prefill <= prefill - 1'b1;
      end
      OP_TRK: begin
        peak_gap  <= dist_c;
        pd        <= pd_c;
        nd        <= nd_c;
        i_cnt     <= AW'(1);
        idx       <= wp_wrap;
        best_i    <= '0;
        best_diff <= '0;
        best_mag  <= '0;
      end
      OP_INC_MUL: begin
        prod_a <= nd * $signed({1'b0, peak_gap});
        prod_b <= pd * $signed({1'b0, len_m1});
      end
      OP_INC_SEL: begin
        div_neg <= num[DIFF_W-1];
        if (take) begin
          pp <= (wp == '0) ? len_m1 : wp - 1'b1;
          pm <= new_mag;
        end
      end
      OP_SC_MAG: begin
        cand_m <= rd_mag;
        cand_d <= $signed({2'b00, rd_mag, 15'b0}) - $signed({2'b00, avg});
      end
      OP_SC_MUL: begin
        prod_a <= cand_d * $signed({1'b0, best_i});
        prod_b <= best_diff * $signed({1'b0, i_cnt});
      end
      OP_SC_CMP: begin
        if ((best_i == '0) || take) begin
          best_i    <= i_cnt;
          best_diff <= cand_d;
          best_mag  <= cand_m;
        end
        i_cnt <= i_cnt + 1'b1;
        idx   <= idx_wrap;
      end
      OP_SC_FIN: begin
        div_neg <= num[DIFF_W-1];
        pp      <= (pp_sum >= len) ? AW'(pp_sum - len) : pp_sum[AW-1:0];
        pm      <= best_mag;
      end
      OP_SLOPE_DIV: begin
        if (div_done) begin
          if (!div_neg) begin
            slope <= (quo > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
          end else begin
            slope <= (quo > DVD_W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_left    <= scale_sat(prod_l);
      out_right   <= two_ch ? scale_sat(prod_r) : '0;
      out_prefill <= prefill != '0;
      out_gain    <= g;
    end
  end

endmodule
`default_nettype wire

[rtl/core/lvl_ctrl.sv]
`default_nettype none
module lvl_ctrl import lvl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_flush,
  input  dp_status_t st,
  output logic       in_ready,
  output dp_op_t     op
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (st.cfg_flush) begin
      state_next = ST_CLR_INIT;
    end else begin
      case (state)
        ST_CLR_INIT:  state_next = ST_CLEAR;
        ST_CLEAR:     if (st.clr_done) state_next = ST_IDLE;
        ST_IDLE:      if (in_valid) state_next = in_flush ? ST_CLR_INIT : ST_G_START;
        ST_G_START: begin
          if (st.amp_zero) begin
            state_next = ST_G_CAP;
          end else if (st.amp_big) begin
            state_next = ST_G_DIV;
          end else begin
            state_next = ST_G_NORM;
          end
        end
        ST_G_DIV:     if (st.div_done) state_next = ST_G_CAP;
        ST_G_NORM:    if (st.norm_done) state_next = ST_G_SQ_MUL;
        ST_G_SQ_MUL:  state_next = ST_G_SQ_UPD;
        ST_G_SQ_UPD:  state_next = st.k_last ? ST_G_LOG : ST_G_SQ_MUL;
        ST_G_LOG:     state_next = ST_G_EXP_CHK;
        ST_G_EXP_CHK: state_next = st.exp_sat ? ST_G_CAP : ST_G_EXP_MUL;
        ST_G_EXP_MUL: state_next = ST_G_EXP_UPD;
        ST_G_EXP_UPD: state_next = st.k_last ? ST_G_EXP_FIN : ST_G_EXP_MUL;
        ST_G_EXP_FIN: state_next = ST_G_CAP;
        ST_G_CAP:     state_next = ST_RING;
        ST_RING:      state_next = ST_SCALE;
        ST_SCALE:     state_next = ST_OUT;
        ST_OUT:       if (!st.out_busy) state_next = ST_TRK;
        ST_TRK:       state_next = st.rescan ? ST_SC_RD : ST_INC_MUL;
        ST_INC_MUL:   state_next = ST_INC_SEL;
        ST_INC_SEL:   state_next = ST_SLOPE_DIV;
        ST_SC_RD:     state_next = ST_SC_MAG;
        ST_SC_MAG:    state_next = ST_SC_MUL;
        ST_SC_MUL:    state_next = ST_SC_CMP;
        ST_SC_CMP:    state_next = st.scan_last ? ST_SC_FIN : ST_SC_RD;
        ST_SC_FIN:    state_next = ST_SLOPE_DIV;
        ST_SLOPE_DIV: if (st.div_done) state_next = ST_IDLE;
        default:      state_next = ST_CLR_INIT;
      endcase
    end
  end

  always_comb begin
    in_ready = (state == ST_IDLE) && !st.cfg_flush;
    op       = OP_NONE;
    case (state)
      ST_CLR_INIT:  op = OP_CLR_INIT;
      ST_CLEAR:     op = OP_CLEAR;
      ST_IDLE:      if (in_valid && in_ready && !in_flush) op = OP_LATCH;
      ST_G_START:   op = OP_G_START;
      ST_G_DIV:     op = OP_G_DIV;
      ST_G_NORM:    op = OP_G_NORM;
      ST_G_SQ_MUL:  op = OP_G_SQ_MUL;
      ST_G_SQ_UPD:  op = OP_G_SQ_UPD;
      ST_G_LOG:     op = OP_G_LOG;
      ST_G_EXP_CHK: op = OP_G_EXP_CHK;
      ST_G_EXP_MUL: op = OP_G_EXP_MUL;
      ST_G_EXP_UPD: op = OP_G_EXP_UPD;
      ST_G_EXP_FIN: op = OP_G_EXP_FIN;
      ST_G_CAP:     op = OP_G_CAP;
      ST_RING:      op = OP_RING;
      ST_SCALE:     op = OP_SCALE;
      ST_OUT:       if (!st.out_busy) op = OP_OUT;
      ST_TRK:       op = OP_TRK;
      ST_INC_MUL:   op = OP_INC_MUL;
      ST_INC_SEL:   op = OP_INC_SEL;
      ST_SC_RD:     op = OP_SC_RD;
      ST_SC_MAG:    op = OP_SC_MAG;
      ST_SC_MUL:    op = OP_SC_MUL;
      ST_SC_CMP:    op = OP_SC_CMP;
      ST_SC_FIN:    op = OP_SC_FIN;
      ST_SLOPE_DIV: op = OP_SLOPE_DIV;
      default:      op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/lookahead_volume_leveler_top.sv]
// Channel   | Dir | Signals              | Payload
// s_axis    | in  | tvalid tready tdata  | tdata: sample_left, sample_right; tuser: command
// m_axis    | out | tvalid tready tdata  | tdata: out_left, out_right, gain_used;
//           |     |                      | tuser: from_prefill
// cfg       | in  | cfg_we cfg_index     | cfg_data: strength, max_gain, length_in_use,
//           |     |                      | channels_in_use
//
// One frame at a time: accept, then the gain: zero at zero amplitude, the serial divider
// for amplitude above unity, else the log2 squaring loop and exp2 product. Then ring write,
// scaling and output; the tracker update is bound by the divider, and when the peak leaves
// the window a rescan of the ring takes the place of the update. Reset, a flush item, or a
// write of length or channel count runs a clearing pass over all 4096 ring entries
// with s_axis_tready low; a result stalled on m_axis holds the next output step.
`default_nettype none
module lookahead_volume_leveler_top import lvl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [15:0] sample_left, [31:16] sample_right
  input  logic              s_axis_tuser,   // [0] command: 0 frame, 1 flush
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // [15:0] out_left, [31:16] out_right,
                                            // [47:32] gain_used
  output logic              m_axis_tuser,   // [0] from_prefill
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  dp_status_t        st;
  dp_op_t            op;
  logic [SMP_W-1:0]  out_left, out_right;
  logic [GAIN_W-1:0] out_gain;

  // sequencer: one state per datapath step
  lvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_flush (s_axis_tuser),
    .st       (st),
    .in_ready (s_axis_tready),
    .op       (op)
  );

  // ring, gain unit, tracker and the result register
  lvl_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_left     (s_axis_tdata[15:0]),
    .in_right    (s_axis_tdata[31:16]),
    .op          (op),
    .st          (st),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_left    (out_left),
    .out_right   (out_right),
    .out_prefill (m_axis_tuser),
    .out_gain    (out_gain)
  );

  assign m_axis_tdata = {out_gain, out_right, out_left};

endmodule
`default_nettype wire

[rtl/core/lvl_checker.sv]
`default_nettype none
module lvl_checker import lvl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        cfg_we,
  input logic [1:0]  cfg_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // reset starts the clearing pass
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("ready right after reset");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after an accepted item");

  // a length or channel write flushes
  a_cfg_flush: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == CFG_LENGTH || cfg_index == CFG_CHANNELS) |=> !s_axis_tready)
    else $error("ready right after a flushing write");

  // frames from the zero fill carry silence
  a_prefill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
    else $error("prefill frame not silent");

endmodule

bind lookahead_volume_leveler_top lvl_checker u_lvl_checker (.*);
`default_nettype wire

[sim/lookahead_volume_leveler_checker.sv]
`default_nettype none
module lookahead_volume_leveler_checker import lvl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  input  wire logic              s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,   // [15:0] sample_left, [31:16] sample_right
  input  wire logic              s_axis_tuser,   // [0] command
  input  wire logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  input  wire logic [47:0]       m_axis_tdata,   // [15:0] out_left, [31:16] out_right,
                                                 // [47:32] gain_used
  input  wire logic              m_axis_tuser,   // [0] from_prefill
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     frames_in,
  output int                     flushes_in,
  output int                     results_out
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] out_left;
    logic [15:0] out_right;
    logic        from_prefill;
    logic [15:0] gain_used;
  } leveled_frame_t;

  // 2^(2^-(8-k)) in Q1.30 for fraction bit k, 0 up to 7 (index = bit number)
  localparam longint unsigned ROOT2_POW [8] = '{
    64'd1076653033, 64'd1079572136, 64'd1085434106, 64'd1097253708,
    64'd1121280435, 64'd1170923762, 64'd1276901417, 64'd1518500250
  };

  leveled_frame_t leveled_q[$];

  logic [7:0]  strength;
  logic [15:0] gain_cap;
  logic [12:0] len_reg;
  logic [1:0]  chan_reg;
  logic [15:0] ring [2][RING_DEPTH];
  int unsigned wr_pos, pk_pos, pk_mag, prefill_cnt;
  int          pk_slope;
  logic [31:0] amp;

  assign pending = leveled_q.size();

  function automatic int unsigned active_len();
    int unsigned l;
    l = 32'(len_reg);
    if (l < 2) l = 2;
    if (l > RING_DEPTH) l = RING_DEPTH;
    return l;
  endfunction

  function automatic int unsigned active_ch();
    int unsigned c;
    c = 32'(chan_reg);
    if (c < 1) c = 1;
    if (c > 2) c = 2;
    return c;
  endfunction

  function automatic int clip_slope(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic int unsigned abs16(logic [15:0] x);
    int s;
    s = $signed(x);
    return (s < 0) ? -s : s;
  endfunction

  function automatic void clear_tracker();
    for (int ch = 0; ch < 2; ch++)
      for (int i = 0; i < RING_DEPTH; i++) ring[ch][i] = '0;
    wr_pos = 0;
    pk_pos = 0;
    pk_slope = 0;
    pk_mag = 0;
    amp = '0;
    prefill_cnt = active_len();
  endfunction

  // Q8.8: 0 if amp is 0, 1/amp over unity, else amp^-strength by log2/exp2; optional cap
  function automatic int unsigned leveling_gain();
    longint unsigned m, r, v;
    int unsigned frac, nlog, e, n, f, g;
    int p;
    if (amp == 0) begin
      g = 0;
    end else if (amp > 32'h4000_0000) begin
      g = int'((64'd1 << 38) / amp);
    end else begin
      p = 30;
      while (!amp[p]) p--;
      m = 64'(amp) << (30 - p);
      frac = 0;
      for (int k = 0; k < 8; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      nlog = (30 - p) * 256 - frac;
      e = (strength * nlog) >> 8;
      n = e >> 8;
      f = e & 255;
      if (n >= 8) begin
        g = 16'hFFFF;
      end else begin
        r = 64'd1 << 30;
        for (int k = 0; k < 8; k++)
          if (f[k]) r = (r * ROOT2_POW[k]) >> 30;
        v = (r << n) >> 22;
        g = (v > 64'hFFFF) ? 16'hFFFF : int'(v);
      end
    end
    if (gain_cap != 0 && g > gain_cap) g = gain_cap;
    return g;
  endfunction

  function automatic leveled_frame_t level_frame(logic [15:0] left, logic [15:0] right);
    leveled_frame_t res;
    int unsigned len, nch, g, new_mag, idx, mg, best_i, best_mag, pk_gap;
    logic [15:0] smp [2];
    longint r, avg, d, best_diff, pd, nd;
    len = active_len();
    nch = active_ch();
    g = leveling_gain();
    smp[0] = left;
    smp[1] = right;
    new_mag = 0;
    res.out_left = '0;
    res.out_right = '0;
    for (int ch = 0; ch < 2; ch++) begin
      r = 0;
      if (ch < nch) begin
        r = (longint'($signed(ring[ch][wr_pos])) * longint'(g)) / 256;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        ring[ch][wr_pos] = smp[ch];
        if (abs16(smp[ch]) > new_mag) new_mag = abs16(smp[ch]);
      end
      if (ch == 0) res.out_left = r[15:0];
      else res.out_right = r[15:0];
    end
    res.from_prefill = (prefill_cnt > 0);
    if (prefill_cnt > 0) prefill_cnt--;
    res.gain_used = g[15:0];

    wr_pos = (wr_pos + 1) % len;
    avg = longint'(amp) + longint'(pk_slope);
    if (avg < 0) avg = 0;
    if (avg > 64'sh0_FFFF_FFFF) avg = 64'sh0_FFFF_FFFF;
    amp = avg[31:0];

    if (wr_pos == pk_pos) begin
      // peak left the window: rescan for the steepest climb, later frame on ties
      best_diff = 0;
      best_i = 0;
      best_mag = 0;
      for (int unsigned i = 1; i < len; i++) begin
        idx = (wr_pos + i) % len;
        mg = 0;
        for (int ch = 0; ch < nch; ch++)
          if (abs16(ring[ch][idx]) > mg) mg = abs16(ring[ch][idx]);
        d = (longint'(mg) << 15) - avg;
        if (best_i == 0 || d * longint'(best_i) >= best_diff * longint'(i)) begin
          best_i = i;
          best_diff = d;
          best_mag = mg;
        end
      end
      pk_pos = (wr_pos + best_i) % len;
      pk_slope = clip_slope(best_diff / longint'(best_i));
      pk_mag = best_mag;
    end else begin
      pk_gap = (pk_pos + len - wr_pos) % len;
      if (pk_gap == 0) pk_gap = 1;
      pd = (longint'(pk_mag) << 15) - avg;
      nd = (longint'(new_mag) << 15) - avg;
      pk_slope = clip_slope(pd / longint'(pk_gap));
      if (nd * longint'(pk_gap) >= pd * longint'(len - 1)) begin
        pk_pos = (wr_pos + len - 1) % len;
        pk_slope = clip_slope(nd / longint'(len - 1));
        pk_mag = new_mag;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    leveled_frame_t want;
    if (rst) begin
      strength = STRENGTH_RST;
      gain_cap = MAX_GAIN_RST;
      len_reg = LENGTH_RST;
      chan_reg = CHANNELS_RST;
      clear_tracker();
      leveled_q.delete();
      fail_count = 0;
      frames_in = 0;
      flushes_in = 0;
      results_out = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STRENGTH: strength = cfg_data[7:0];
          CFG_MAX_GAIN: gain_cap = cfg_data[15:0];
          CFG_LENGTH: begin
            len_reg = cfg_data[12:0];
            clear_tracker();
          end
          CFG_CHANNELS: begin
            chan_reg = cfg_data[1:0];
            clear_tracker();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          clear_tracker();
          flushes_in++;
        end else begin
          leveled_q.push_back(level_frame(s_axis_tdata[15:0], s_axis_tdata[31:16]));
          frames_in++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        if (leveled_q.size() == 0) begin
          $error("unexpected result: out_left %0d", $signed(m_axis_tdata[15:0]));
          fail_count++;
        end else begin
          want = leveled_q.pop_front();
          if (m_axis_tdata[15:0] !== want.out_left) begin
            $error("out_left: expected %0d actual %0d",
                   $signed(want.out_left), $signed(m_axis_tdata[15:0]));
            fail_count++;
          end
          if (m_axis_tdata[31:16] !== want.out_right) begin
            $error("out_right: expected %0d actual %0d",
                   $signed(want.out_right), $signed(m_axis_tdata[31:16]));
            fail_count++;
          end
          if (m_axis_tdata[47:32] !== want.gain_used) begin
            $error("gain_used: expected %0d actual %0d", want.gain_used,
                   m_axis_tdata[47:32]);
            fail_count++;
          end
          if (m_axis_tuser !== want.from_prefill) begin
            $error("from_prefill: expected %0d actual %0d", want.from_prefill,
                   m_axis_tuser);
            fail_count++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;
  import lvl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // [15:0] sample_left, [31:16] sample_right
  logic              s_axis_tuser = 1'b0; // [0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;        // [15:0] out_left, [31:16] out_right,
                                          // [47:32] gain_used
  logic              m_axis_tuser;        // [0] from_prefill
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  int fail_count, pending, frames_in, flushes_in, results_out;

  // random idling on both sides; cleared for one phase to get a back-to-back stretch
  bit idling_on = 1'b1;
  // set by the stimulus to make the receiver hold off for a long stretch
  bit hold_off_req = 1'b0;
  int unsigned ring_len = RING_DEPTH;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;
  localparam int   N_PHASES  = 9;

  lookahead_volume_leveler_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lookahead_volume_leveler_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .frames_in(frames_in),
    .flushes_in(flushes_in), .results_out(results_out)
  );

  always #10 clk = ~clk;

  // Hard stop: far beyond the slowest legal run, including clearing passes and rescans.
  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", pending);
    $display("lookahead_volume_leveler_top verification failed");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        m_axis_tready <= !(idling_on && $urandom_range(99) < 20);
      end
    end
  end

  // Offer one item and hold it until accepted. Valid stays high into the next call
  // unless a gap is taken, so it is never lowered and raised in the same step.
  task automatic send_item(logic cmd, logic [15:0] left, logic [15:0] right);
    while (idling_on && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {right, left};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid, drain every result, then let a pending rescan or clearing pass finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4 * ring_len + 4400) @(posedge clk);
  endtask

  task automatic write_settings(logic [7:0] str, logic [15:0] cap, logic [12:0] len,
                                logic [1:0] nch);
    int unsigned l;
    cfg_we <= 1'b1;
    cfg_index <= CFG_STRENGTH;  cfg_data <= CFG_W'(str);  @(posedge clk);
    cfg_index <= CFG_MAX_GAIN;  cfg_data <= cap;          @(posedge clk);
    cfg_index <= CFG_LENGTH;    cfg_data <= CFG_W'(len);  @(posedge clk);
    cfg_index <= CFG_CHANNELS;  cfg_data <= CFG_W'(nch);  @(posedge clk);
    cfg_we <= 1'b0;
    l = 32'(len);
    ring_len = (l < 2) ? 2 : (l > RING_DEPTH) ? RING_DEPTH : l;
  endtask

  // Mix of extremes, full-scale noise and quieter passages for the tracker to chase.
  function automatic logic [15:0] pick_sample();
    logic signed [15:0] x;
    case ($urandom_range(9))
      0: x = 16'sh8000;
      1: x = 16'sh7FFF;
      2: x = 16'sh0000;
      3, 4, 5: x = 16'($urandom);
      default: x = $signed(16'($urandom)) >>> $urandom_range(1, 14);
    endcase
    return x;
  endfunction

  initial begin
    logic [7:0]  ph_str [N_PHASES];
    logic [15:0] ph_cap [N_PHASES];
    logic [12:0] ph_len [N_PHASES];
    logic [1:0]  ph_ch  [N_PHASES];
    int          ph_cnt [N_PHASES];
    // extremes and clamped values, random settings, a clamped length, a back-to-back phase, random again
    ph_str = '{8'd255, 8'd0,      8'd128,  8'd0, 8'd0, 8'd0, 8'd204,   8'd0,  8'd0};
    ph_cap = '{16'd0,  16'hFFFF,  16'd256, 0,    0,    0,    16'd5120, 16'd0, 0};
    ph_len = '{13'd2,  13'd7,     13'd0,   13'd1, 0,   0,    13'h1FFF, 13'd16, 0};
    ph_ch  = '{2'd2,   2'd1,      2'd3,    2'd0,  0,   0,    2'd2,     2'd2,  0};
    ph_cnt = '{35,     35,        25,      20,    35,  35,   12,       40,    30};
    for (int i = 3; i < 6; i++) begin
      ph_str[i] = 8'($urandom);
      ph_cap[i] = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
      ph_len[i] = (i == 3) ? 13'd1 : 13'($urandom_range(3, 40));
      ph_ch[i]  = 2'($urandom);
    end
    ph_str[8] = 8'($urandom);
    ph_cap[8] = 16'($urandom);
    ph_len[8] = 13'($urandom_range(2, 12));
    ph_ch[8]  = 2'($urandom_range(1, 2));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A few frames at the reset settings: all from the zero fill of the full ring.
    repeat (3) send_item(CMD_FRAME, pick_sample(), pick_sample());
    settle();

    // Directed: short ring, both channels, extremes and flushes.
    write_settings(8'd204, 16'd5120, 13'd4, 2'd2);
    send_item(CMD_FRAME, 16'h7FFF, 16'h8000);
    send_item(CMD_FRAME, 16'h8000, 16'h7FFF);
    send_item(CMD_FRAME, 16'hFFFF, 16'h0001);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0001, 16'hFFFF);
    send_item(CMD_FRAME, 16'h7FFF, 16'h7FFF);
    send_item(CMD_FLUSH, 16'hFFFF, 16'hFFFF);
    send_item(CMD_FRAME, 16'h8000, 16'h8000);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h4000, 16'hC000);
    send_item(CMD_FRAME, 16'h0100, 16'hFF00);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0003, 16'hFFFD);
    send_item(CMD_FRAME, 16'h5555, 16'hAAAA);
    send_item(CMD_FRAME, 16'hAAAA, 16'h5555);
    send_item(CMD_FLUSH, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h7FFF, 16'h0000);
    settle();

    // Random phases, each under its own settings; writes only with the block idle.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_settings(ph_str[ph], ph_cap[ph], ph_len[ph], ph_ch[ph]);
      idling_on = (ph != 7);
      for (int n = 0; n < ph_cnt[ph]; n++) begin
        if (ph == 1 && n == 10) hold_off_req = 1'b1;
        if ($urandom_range(99) < 3)
          send_item(CMD_FLUSH, 16'($urandom), 16'($urandom));
        else
          send_item(CMD_FRAME, pick_sample(), pick_sample());
      end
      settle();
    end

    $display("covered %0d frames and %0d flushes over %0d settings, %0d results checked",
             frames_in, flushes_in, N_PHASES + 2, results_out);
    if (fail_count == 0 && pending == 0) begin
      $display("lookahead_volume_leveler_top verification clean");
    end else begin
      $display("lookahead_volume_leveler_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
